// File: rtl/core/bfah_pkg.sv
// shared types and constants of the best-fit aligned heap allocator
// no dependencies; used by every module of the block
package bfah_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 64;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_MERGE,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NO_FIT    = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_code_type;

   typedef enum logic {
      CSR_HEAP_START = 1'b0,
      CSR_HEAP_SIZE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic init_tbl;
      logic csr_wr;
      logic load_req;
      logic rd;
      logic chunk_pass;
      logic merge;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic free_mode;
      logic chunk_found;
      logic out_busy;
   } sts_type;

endpackage

// File: rtl/core/bfah_ctrl.sv
// sequencer of the heap allocator: table scans, merge and commit steps
// depends on bfah_pkg
module bfah_ctrl #(
   parameter int unsigned TABLE_ENTRIES = bfah_pkg::TABLE_ENTRIES_DEF,
   localparam int unsigned IW = $clog2(TABLE_ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_mode,
   output logic              req_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   output bfah_pkg::cmd_type cmd,
   output logic [IW-1:0]     rd_idx,
   input  bfah_pkg::sts_type sts
);

   localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

   bfah_pkg::state_type state_ff, state_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic                pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfah_pkg::ST_INIT;
         cnt_ff   <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   assign rd_idx = cnt_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         bfah_pkg::ST_INIT: begin
            cmd.init_tbl = 1'b1;
            state_in     = bfah_pkg::ST_IDLE;
         end
         bfah_pkg::ST_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.csr_wr = 1'b1;
               state_in   = bfah_pkg::ST_INIT;
            end else if (req_valid) begin
               cmd.load_req = 1'b1;
               pass_in      = req_mode;
               cnt_in       = '0;
               state_in     = bfah_pkg::ST_SCAN;
            end
         end
         bfah_pkg::ST_SCAN: begin
            cmd.rd         = 1'b1;
            cmd.chunk_pass = pass_ff;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = bfah_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         bfah_pkg::ST_DRAIN: begin
            state_in = bfah_pkg::ST_DECIDE;
         end
         bfah_pkg::ST_DECIDE: begin
            if (sts.free_mode && pass_ff) begin
               if (sts.chunk_found) begin
                  pass_in  = 1'b0;
                  state_in = bfah_pkg::ST_SCAN;
               end else begin
                  state_in = bfah_pkg::ST_COMMIT;
               end
            end else if (sts.free_mode) begin
               state_in = bfah_pkg::ST_MERGE;
            end else begin
               state_in = bfah_pkg::ST_COMMIT;
            end
         end
         bfah_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = bfah_pkg::ST_COMMIT;
         end
         bfah_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = bfah_pkg::ST_DONE;
         end
         bfah_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = bfah_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfah_pkg::ST_INIT;
         end
      endcase
   end

endmodule

// File: rtl/core/bfah_dpath.sv
// datapath of the heap allocator: tables, scan evaluation, table updates
// depends on bfah_pkg
module bfah_dpath #(
   parameter int unsigned TABLE_ENTRIES = bfah_pkg::TABLE_ENTRIES_DEF,
   localparam int unsigned IW = $clog2(TABLE_ENTRIES)
) (
   input  logic              clock,
   input  logic              reset,
   input  bfah_pkg::cmd_type cmd,
   input  logic [IW-1:0]     rd_idx,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   input  logic              req_mode,
   input  logic [31:0]       req_alloc_size,
   input  logic [4:0]        req_align_log2,
   input  logic [31:0]       req_free_address,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [31:0]       rsp_result_address,
   output logic [1:0]        rsp_status,
   output bfah_pkg::sts_type sts
);

   // table memories
   logic [31:0] fb_mem [TABLE_ENTRIES];
   logic [31:0] fl_mem [TABLE_ENTRIES];
   logic [31:0] cb_mem [TABLE_ENTRIES];
   logic [31:0] cl_mem [TABLE_ENTRIES];
   logic [31:0] fb_rd_ff, fl_rd_ff, cb_rd_ff, cl_rd_ff;

   logic [TABLE_ENTRIES-1:0] fu_ff, fu_in, cu_ff, cu_in;

   logic [31:0] hs_ff, hz_ff;
   logic        mode_ff;
   logic [31:0] size_ff, faddr_ff;
   logic [4:0]  align_ff;

   logic          ev_vld_ff, ev_chunk_ff;
   logic [IW-1:0] ev_idx_ff;

   logic          best_vld_ff, ec_vld_ff, c_vld_ff, l_vld_ff, r_vld_ff, ef_vld_ff;
   logic [IW-1:0] best_idx_ff, ec_idx_ff, c_idx_ff, l_idx_ff, r_idx_ff, ef_idx_ff;
   logic [31:0]   best_b_ff, best_l_ff, best_pad_ff;
   logic [31:0]   c_b_ff, c_len_ff, l_b_ff, l_len_ff, r_len_ff;
   logic [33:0]   nl_ff;

   bfah_pkg::status_code_type res_sts;
   logic [31:0]               res_addr;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_addr_ff, res_addr_ff;
   bfah_pkg::status_code_type rsp_sts_ff, res_sts_ff;

   // scan evaluation
   logic [31:0] mask, pad;
   logic [33:0] need;
   logic        fits, better, f_used, c_used;
   logic [32:0] f_end, c_end;
   logic        lm, rm, fp;
   logic        a_take, c_take, l_take, r_take, ef_take, ec_take;

   always_comb begin
      mask    = ~(32'hFFFF_FFFF << align_ff);
      pad     = (~fb_rd_ff + 32'd1) & mask;
      need    = {2'b00, pad} + {2'b00, size_ff};
      fits    = need <= {2'b00, fl_rd_ff};
      f_used  = fu_ff[ev_idx_ff];
      c_used  = cu_ff[ev_idx_ff];
      better  = !best_vld_ff || (fl_rd_ff < best_l_ff) ||
                ((fl_rd_ff == best_l_ff) && (fb_rd_ff < best_b_ff));
      a_take  = ev_vld_ff && !ev_chunk_ff && !mode_ff && f_used && fits && better;
      c_take  = ev_vld_ff && ev_chunk_ff && c_used && (cb_rd_ff <= faddr_ff) &&
                (!c_vld_ff || (cb_rd_ff > c_b_ff));
      f_end   = {1'b0, fb_rd_ff} + {1'b0, fl_rd_ff};
      c_end   = {1'b0, c_b_ff} + {1'b0, c_len_ff};
      lm      = f_used && (f_end == {1'b0, c_b_ff});
      rm      = f_used && ({1'b0, fb_rd_ff} == c_end);
      fp      = ev_vld_ff && !ev_chunk_ff && mode_ff;
      l_take  = fp && lm && !l_vld_ff;
      // an entry that becomes the left neighbour is never the right one
      r_take  = fp && rm && !r_vld_ff && !(lm && !l_vld_ff);
      ef_take = ev_vld_ff && !ev_chunk_ff && !f_used && !ef_vld_ff;
      ec_take = ev_vld_ff && !ev_chunk_ff && !c_used && !ec_vld_ff;
   end

   // update values
   logic [32:0]   room;
   logic [31:0]   clip;
   logic [32:0]   a_al;
   logic [31:0]   a_clen, tail_beg;
   logic [33:0]   tail_len;
   logic          slot_ok;
   logic [IW-1:0] slot;
   logic          f_we, c_we;
   logic [IW-1:0] f_wa;
   logic [31:0]   fb_wd, fl_wd;

   always_comb begin
      room     = 33'h1_0000_0000 - {1'b0, hs_ff};
      clip     = ({1'b0, hz_ff} > room) ? room[31:0] : hz_ff;
      a_al     = {1'b0, best_b_ff} + {1'b0, best_pad_ff};
      a_clen   = best_pad_ff + size_ff;
      tail_beg = best_b_ff + best_pad_ff + size_ff;
      tail_len = {2'b00, best_l_ff} - ({2'b00, best_pad_ff} + {2'b00, size_ff});
      slot_ok  = l_vld_ff || r_vld_ff || ef_vld_ff;
      slot     = l_vld_ff ? l_idx_ff : (r_vld_ff ? r_idx_ff : ef_idx_ff);

      fu_in    = fu_ff;
      cu_in    = cu_ff;
      f_we     = 1'b0;
      f_wa     = '0;
      fb_wd    = hs_ff;
      fl_wd    = clip;
      c_we     = 1'b0;
      res_sts  = bfah_pkg::STS_OK;
      res_addr = '0;
      if (cmd.init_tbl) begin
         fu_in    = '0;
         fu_in[0] = 1'b1;
         cu_in    = '0;
         f_we     = 1'b1;
      end else if (cmd.commit) begin
         if (!mode_ff) begin
            if (!best_vld_ff) begin
               res_sts = bfah_pkg::STS_NO_FIT;
            end else if (!ec_vld_ff) begin
               res_sts = bfah_pkg::STS_FULL;
            end else begin
               cu_in[ec_idx_ff] = 1'b1;
               c_we             = 1'b1;
               res_addr         = a_al[31:0];
               if (tail_len != '0) begin
                  f_we  = 1'b1;
                  f_wa  = best_idx_ff;
                  fb_wd = tail_beg;
                  fl_wd = tail_len[31:0];
               end else begin
                  fu_in[best_idx_ff] = 1'b0;
               end
            end
         end else begin
            if (!c_vld_ff) begin
               res_sts = bfah_pkg::STS_NOT_FOUND;
            end else if (!slot_ok && (nl_ff != '0)) begin
               res_sts = bfah_pkg::STS_FULL;
            end else begin
               cu_in[c_idx_ff] = 1'b0;
               if (l_vld_ff) begin
                  fu_in[l_idx_ff] = 1'b0;
               end
               if (r_vld_ff) begin
                  fu_in[r_idx_ff] = 1'b0;
               end
               if (nl_ff != '0) begin
                  fu_in[slot] = 1'b1;
                  f_we        = 1'b1;
                  f_wa        = slot;
                  fb_wd       = l_vld_ff ? l_b_ff : c_b_ff;
                  fl_wd       = nl_ff[31:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fb_mem[f_wa] <= fb_wd;
         fl_mem[f_wa] <= fl_wd;
      end
      fb_rd_ff <= fb_mem[rd_idx];
      fl_rd_ff <= fl_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         cb_mem[ec_idx_ff] <= best_b_ff;
         cl_mem[ec_idx_ff] <= a_clen;
      end
      cb_rd_ff <= cb_mem[rd_idx];
      cl_rd_ff <= cl_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fu_ff        <= '0;
         cu_ff        <= '0;
         hs_ff        <= '0;
         hz_ff        <= '0;
         ev_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         ec_vld_ff    <= 1'b0;
         c_vld_ff     <= 1'b0;
         l_vld_ff     <= 1'b0;
         r_vld_ff     <= 1'b0;
         ef_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fu_ff     <= fu_in;
         cu_ff     <= cu_in;
         ev_vld_ff <= cmd.rd;
         if (cmd.csr_wr) begin
            if (csr_index == bfah_pkg::CSR_HEAP_START) begin
               hs_ff <= csr_data;
            end else begin
               hz_ff <= csr_data;
            end
         end
         if (cmd.load_req) begin
            best_vld_ff <= 1'b0;
            ec_vld_ff   <= 1'b0;
            c_vld_ff    <= 1'b0;
            l_vld_ff    <= 1'b0;
            r_vld_ff    <= 1'b0;
            ef_vld_ff   <= 1'b0;
         end else begin
            if (a_take) begin
               best_vld_ff <= 1'b1;
            end
            if (ec_take) begin
               ec_vld_ff <= 1'b1;
            end
            if (c_take) begin
               c_vld_ff <= 1'b1;
            end
            if (l_take) begin
               l_vld_ff <= 1'b1;
            end
            if (r_take) begin
               r_vld_ff <= 1'b1;
            end
            if (ef_take) begin
               ef_vld_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_chunk_ff <= cmd.chunk_pass;
      ev_idx_ff   <= rd_idx;
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         size_ff  <= req_alloc_size;
         align_ff <= req_align_log2;
         faddr_ff <= req_free_address;
      end
      if (a_take) begin
         best_idx_ff <= ev_idx_ff;
         best_b_ff   <= fb_rd_ff;
         best_l_ff   <= fl_rd_ff;
         best_pad_ff <= pad;
      end
      if (ec_take) begin
         ec_idx_ff <= ev_idx_ff;
      end
      if (c_take) begin
         c_idx_ff <= ev_idx_ff;
         c_b_ff   <= cb_rd_ff;
         c_len_ff <= cl_rd_ff;
      end
      if (l_take) begin
         l_idx_ff <= ev_idx_ff;
         l_b_ff   <= fb_rd_ff;
         l_len_ff <= fl_rd_ff;
      end
      if (r_take) begin
         r_idx_ff <= ev_idx_ff;
         r_len_ff <= fl_rd_ff;
      end
      if (ef_take) begin
         ef_idx_ff <= ev_idx_ff;
      end
      if (cmd.merge) begin
         nl_ff <= {2'b00, c_len_ff} + (l_vld_ff ? {2'b00, l_len_ff} : 34'd0) +
                  (r_vld_ff ? {2'b00, r_len_ff} : 34'd0);
      end
      if (cmd.commit) begin
         res_sts_ff  <= res_sts;
         res_addr_ff <= res_addr;
      end
      if (cmd.emit) begin
         rsp_sts_ff  <= res_sts_ff;
         rsp_addr_ff <= res_addr_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_sts_ff;

   assign sts.free_mode   = mode_ff;
   assign sts.chunk_found = c_vld_ff;
   assign sts.out_busy    = rsp_valid_ff && rsp_stall;

endmodule

// File: rtl/core/best_fit_aligned_heap_allocator.sv
// top level of the best-fit aligned heap allocator
// depends on bfah_pkg, bfah_ctrl and bfah_dpath
//
// channel   direction  handshake              word
// req       in         req_valid / req_stall  mode, alloc size, align log2, free address
// rsp       out        rsp_valid / rsp_stall  result address, status
// csr       in         csr_valid / csr_ready  register index, write data
//
// one request at a time; an allocate makes one pass over the free table, a free
// a pass over the chunk table, then, if the chunk is found, one over the free
// table; the single read port of each table memory sets the scan at one entry
// per cycle
// after reset and after every csr write the ST_INIT state rebuilds the tables
// a new request is taken while the previous word still waits on rsp_stall
module best_fit_aligned_heap_allocator #(
   parameter int unsigned TABLE_ENTRIES = bfah_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_alloc_size,
   input  logic [4:0]  req_align_log2,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);

   // command and status between sequencer and datapath
   bfah_pkg::cmd_type cmd;
   bfah_pkg::sts_type sts;
   logic [IW-1:0]     rd_idx;

   bfah_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .sts       (sts)
   );

   // tables, best-fit search, neighbour search and merge
   bfah_dpath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .rd_idx             (rd_idx),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_mode           (req_mode),
      .req_alloc_size     (req_alloc_size),
      .req_align_log2     (req_align_log2),
      .req_free_address   (req_free_address),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .sts                (sts)
   );

endmodule

// File: rtl/core/bfah_checker.sv
// port-level checks of the heap allocator, bound to the top level
// depends on bfah_pkg and best_fit_aligned_heap_allocator
module bfah_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_address,
   input logic [1:0]  rsp_status,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bfah_pkg::STS_OK) |-> rsp_result_address == 32'd0)
      else $error("failed request returned an address");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("request taken while busy");

   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !csr_ready && req_stall)
      else $error("table rebuild skipped after csr write");

endmodule

bind best_fit_aligned_heap_allocator bfah_checker u_bfah_checker (.*);

// File: test/best_fit_aligned_heap_allocator_tb.sv
// self-checking testbench for best_fit_aligned_heap_allocator: a directed table, then random
// allocate/free traffic over several heap settings, checked against an in-bench table model
// depends on bfah_pkg and the rtl of the allocator
module best_fit_aligned_heap_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 64;
   // the worst free pass scans the chunk table, then the free table; wait well beyond it
   localparam int SETTLE_CYCLES = 3 * ENTRIES + 40;
   localparam int MODE_ALLOC = 0;
   localparam int MODE_FREE = 1;

   typedef struct {
      bit [31:0]                 addr;
      bfah_pkg::status_code_type status;
   } grant_word_type;

   // one line of the directed table; is_csr rows write a register instead
   typedef struct {
      bit                        is_csr;
      bit                        mode;
      bit [31:0]                 size;
      bit [4:0]                  align;
      bit [31:0]                 addr;
      bit                        typed;
      bit [31:0]                 exp_addr;
      bfah_pkg::status_code_type exp_status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_alloc_size = '0;
   logic [4:0]  req_align_log2 = '0;
   logic [31:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_address;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   // heap model: settings and both tables
   bit [31:0] heap_base, heap_len;
   bit [31:0] hole_begin [ENTRIES];
   bit [31:0] hole_length [ENTRIES];
   bit        hole_used [ENTRIES];
   bit [31:0] chunk_begin [ENTRIES];
   bit [31:0] chunk_length [ENTRIES];
   bit        chunk_used [ENTRIES];

   grant_word_type pending_grants[$];
   bit [31:0]      live_addrs[$];
   int             errors = 0;
   bit             quiet = 1'b0;

   best_fit_aligned_heap_allocator i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // rebuild both tables from the current settings, clipping at the top of memory
   function automatic void heap_rebuild();
      bit [63:0] room, len;
      room = 64'h1_0000_0000 - heap_base;
      len = heap_len;
      if (len > room) len = room;
      for (int i = 0; i < ENTRIES; i++) begin
         hole_begin[i] = '0; hole_length[i] = '0; hole_used[i] = 1'b0;
         chunk_begin[i] = '0; chunk_length[i] = '0; chunk_used[i] = 1'b0;
      end
      hole_begin[0] = heap_base;
      hole_length[0] = len[31:0];
      hole_used[0] = 1'b1;
   endfunction

   function automatic grant_word_type alloc_grant(bit [31:0] size, bit [4:0] p);
      grant_word_type g;
      bit [63:0] mask, b, l, al, best_al, tail_beg, tail_len;
      int best, c;
      g.addr = '0;
      best = -1;
      best_al = '0;
      mask = (64'd1 << p) - 1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!hole_used[i]) continue;
         b = hole_begin[i];
         l = hole_length[i];
         al = ((b + mask) >> p) << p;
         if (al - b + size > l) continue;
         if (best < 0 || l < hole_length[best] ||
             (l == hole_length[best] && b < hole_begin[best])) begin
            best = i;
            best_al = al;
         end
      end
      if (best < 0) begin
         g.status = bfah_pkg::STS_NO_FIT;
         return g;
      end
      c = -1;
      for (int i = 0; i < ENTRIES && c < 0; i++)
         if (!chunk_used[i]) c = i;
      if (c < 0) begin
         g.status = bfah_pkg::STS_FULL;
         return g;
      end
      chunk_used[c] = 1'b1;
      chunk_begin[c] = hole_begin[best];
      chunk_length[c] = 32'(best_al - hole_begin[best] + size);
      tail_beg = best_al + size;
      tail_len = 64'(hole_begin[best]) + hole_length[best] - tail_beg;
      if (tail_len > 0) begin
         hole_begin[best] = tail_beg[31:0];
         hole_length[best] = tail_len[31:0];
      end else begin
         hole_used[best] = 1'b0;
      end
      g.addr = best_al[31:0];
      g.status = bfah_pkg::STS_OK;
      return g;
   endfunction

   function automatic grant_word_type release_grant(bit [31:0] addr);
      grant_word_type g;
      int c, left, right, slot;
      bit [63:0] cb, ce, nb, nl;
      g.addr = '0;
      c = -1; left = -1; right = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (chunk_used[i] && chunk_begin[i] <= addr &&
             (c < 0 || chunk_begin[i] > chunk_begin[c])) c = i;
      if (c < 0) begin
         g.status = bfah_pkg::STS_NOT_FOUND;
         return g;
      end
      cb = chunk_begin[c];
      ce = cb + chunk_length[c];
      for (int i = 0; i < ENTRIES && left < 0; i++)
         if (hole_used[i] && 64'(hole_begin[i]) + hole_length[i] == cb) left = i;
      for (int i = 0; i < ENTRIES && right < 0; i++)
         if (hole_used[i] && i != left && 64'(hole_begin[i]) == ce) right = i;
      nb = (left >= 0) ? 64'(hole_begin[left]) : cb;
      nl = chunk_length[c];
      if (left >= 0) nl += hole_length[left];
      if (right >= 0) nl += hole_length[right];
      slot = (left >= 0) ? left : right;
      if (slot < 0 && nl > 0) begin
         for (int i = 0; i < ENTRIES && slot < 0; i++)
            if (!hole_used[i]) slot = i;
         if (slot < 0) begin
            g.status = bfah_pkg::STS_FULL;
            return g;
         end
      end
      chunk_used[c] = 1'b0;
      if (left >= 0) hole_used[left] = 1'b0;
      if (right >= 0) hole_used[right] = 1'b0;
      if (nl > 0) begin
         hole_used[slot] = 1'b1;
         hole_begin[slot] = nb[31:0];
         hole_length[slot] = nl[31:0];
      end
      g.status = bfah_pkg::STS_OK;
      return g;
   endfunction

   // drop the request, wait until every result is in, plus a margin for a pass to finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only ever issued while the block is idle
   task automatic csr_write(bfah_pkg::csr_index_type idx, bit [31:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == bfah_pkg::CSR_HEAP_START) heap_base = value;
      else heap_len = value;
      heap_rebuild();
      live_addrs.delete();
   endtask

   // present one request word with a random lead gap, then queue its expectation
   task automatic send_req(bit mode, bit [31:0] size, bit [4:0] align, bit [31:0] addr,
                           bit typed, bit [31:0] exp_addr,
                           bfah_pkg::status_code_type exp_status);
      int gap;
      grant_word_type g;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_alloc_size <= size;
      req_align_log2 <= align;
      req_free_address <= addr;
      do @(posedge clock); while (req_stall);
      g = (mode == MODE_ALLOC) ? alloc_grant(size, align) : release_grant(addr);
      if (mode == MODE_ALLOC && g.status == bfah_pkg::STS_OK) live_addrs.push_back(g.addr);
      if (typed) begin
         g.addr = exp_addr;
         g.status = exp_status;
      end
      pending_grants.push_back(g);
   endtask

   // result side: random stall before every word
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      grant_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected word addr %h status %0d", $time,
                     rsp_result_address, rsp_status);
            errors++;
         end else begin
            e = pending_grants.pop_front();
            if (rsp_result_address !== e.addr) begin
               $display("%0t: address expected %h actual %h", $time, e.addr,
                        rsp_result_address);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("best_fit_aligned_heap_allocator_tb: errors");
      $finish;
   end

   initial begin
      stim_row_type rows[];
      bit [31:0] starts[6];
      bit [31:0] sizes[6];
      bit [31:0] sz, ad;
      bit [4:0] al;
      int alloc_pct, k;

      heap_base = '0;
      heap_len = '0;
      heap_heap_init: heap_rebuild();
      // directed part; csr rows carry index in mode and value in size
      rows = '{
         // empty heap after reset
         '{0, MODE_ALLOC, 32'd1, 5'd0, 32'd0, 1, 32'd0, bfah_pkg::STS_NO_FIT},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'd0, 1, 32'd0, bfah_pkg::STS_NOT_FOUND},
         '{0, MODE_ALLOC, 32'd0, 5'd0, 32'd0, 1, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'hffff_ffff, 1, 32'd0, bfah_pkg::STS_OK},
         // small heap with alignment pads, mid-chunk and past-end frees
         '{1, bfah_pkg::CSR_HEAP_START, 32'h0000_0104, 5'd0, 32'd0, 0, 32'd0,
           bfah_pkg::STS_OK},
         '{1, bfah_pkg::CSR_HEAP_SIZE, 32'h0000_1000, 5'd0, 32'd0, 0, 32'd0,
           bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'hffff_ffff, 5'd0, 32'd0, 1, 32'd0, bfah_pkg::STS_NO_FIT},
         '{0, MODE_ALLOC, 32'd1, 5'd31, 32'd0, 1, 32'd0, bfah_pkg::STS_NO_FIT},
         '{0, MODE_ALLOC, 32'h10, 5'd4, 32'd0, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'h20, 5'd8, 32'd0, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'h7, 5'd0, 32'd0, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'h0000_0100, 1, 32'd0, bfah_pkg::STS_NOT_FOUND},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'h0000_0208, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'hffff_ffff, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'h0000_0104, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'h1000, 5'd0, 32'd0, 0, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'd0, 5'd0, 32'd0, 0, 32'd0, bfah_pkg::STS_OK},
         // range that runs past the top of memory is clipped
         '{1, bfah_pkg::CSR_HEAP_START, 32'hffff_ff00, 5'd0, 32'd0, 0, 32'd0,
           bfah_pkg::STS_OK},
         '{1, bfah_pkg::CSR_HEAP_SIZE, 32'hffff_ffff, 5'd0, 32'd0, 0, 32'd0,
           bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'h100, 5'd0, 32'd0, 1, 32'hffff_ff00, bfah_pkg::STS_OK},
         '{0, MODE_FREE, 32'd0, 5'd0, 32'hffff_ffff, 1, 32'd0, bfah_pkg::STS_OK},
         '{0, MODE_ALLOC, 32'h1, 5'd8, 32'd0, 1, 32'hffff_ff00, bfah_pkg::STS_OK}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_csr)
            csr_write(bfah_pkg::csr_index_type'(rows[i].mode), rows[i].size);
         else send_req(rows[i].mode, rows[i].size, rows[i].align, rows[i].addr,
                       rows[i].typed, rows[i].exp_addr, rows[i].exp_status);
      end

      // random part over several heap settings, extremes included
      starts = '{32'h0000_1000, 32'h0, 32'hffff_f000, $urandom, 32'h40, 32'h8000_0000};
      sizes = '{32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, $urandom, 32'h200, 32'h0};
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(bfah_pkg::CSR_HEAP_START, starts[ph]);
         csr_write(bfah_pkg::CSR_HEAP_SIZE, sizes[ph]);
         // one phase leans on allocation to fill the chunk table
         alloc_pct = (ph == 0) ? 85 : 55;
         for (int n = 0; n < 85; n++) begin
            if (n % 30 == 0) quiet = ($urandom_range(0, 2) == 0);
            // hold the sender until everything is back
            if (n == 40) wait_idle();
            if ($urandom_range(1, 100) <= alloc_pct) begin
               sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
               al = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
               send_req(MODE_ALLOC, sz, al, $urandom, 0, '0, bfah_pkg::STS_OK);
            end else begin
               if (live_addrs.size() != 0 && $urandom_range(0, 4) != 0) begin
                  k = $urandom_range(0, live_addrs.size() - 1);
                  ad = live_addrs[k] + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0);
                  live_addrs.delete(k);
               end else begin
                  ad = $urandom;
               end
               send_req(MODE_FREE, $urandom, 5'($urandom), ad, 0, '0, bfah_pkg::STS_OK);
            end
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("best_fit_aligned_heap_allocator_tb: clean");
      else
         $display("best_fit_aligned_heap_allocator_tb: errors");
      $finish;
   end

endmodule
